@@ rtl/fdeq_pkg.sv @@
// Package for the fixed-delay event queue: payload structs, codes and widths
// shared by the front, back, result queue and top level. No dependencies.
`timescale 1ns / 1ps

package fdeq_pkg;

  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int MAXH_W    = 6;
  localparam int CFG_W     = 16;
  // holds any bound up to the largest supported queue depth (64)
  localparam int BOUND_W   = 7;
  localparam int MAX_OUT   = 32;
  localparam int RUN_W     = 6;

  localparam logic FUNC_ARRIVE  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic CFG_DELAY    = 1'b0;
  localparam logic CFG_MAX_HELD = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] conn;
    logic [7:0]  chan;
    logic [7:0]  reason;
    logic [15:0] payload;
  } desc_t;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    desc_t             desc;
  } entry_t;

  // time_ms is the due time for an arrival, the release time otherwise
  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  time_ms;
    logic [BOUND_W-1:0] bound;
    desc_t              desc;
  } cmd_t;

  typedef struct packed {
    desc_t             desc;
    logic [TIME_W-1:0] dropped;
    logic              last;
  } result_t;

endpackage

@@ rtl/fdeq_front.sv @@
// Front end: accepts input transactions, stamps due times, snapshots the
// holding bound and queues commands for the back end. Uses fdeq_pkg.
`timescale 1ns / 1ps

module fdeq_front #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        func,
  input  logic [31:0]                 now_ms,
  input  fdeq_pkg::desc_t             desc_in,
  input  logic [fdeq_pkg::DELAY_W-1:0] delay_ms,
  input  logic [fdeq_pkg::MAXH_W-1:0]  max_held,
  output logic                        cmd_valid,
  output fdeq_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);
  import fdeq_pkg::*;

  cmd_t               q [2];
  logic               wp, rp;
  logic [1:0]         cnt;
  logic [BOUND_W-1:0] mh_ext, bound;
  cmd_t               cmd_in;
  logic               do_push, do_pop;

  always_comb begin
    mh_ext = BOUND_W'(max_held);
    if (mh_ext == '0) begin
      bound = BOUND_W'(1);
    end else if (mh_ext > BOUND_W'(QUEUE_DEPTH)) begin
      bound = BOUND_W'(QUEUE_DEPTH);
    end else begin
      bound = mh_ext;
    end
    cmd_in.func    = func;
    cmd_in.time_ms = (func == FUNC_RELEASE) ? now_ms : now_ms + TIME_W'(delay_ms);
    cmd_in.bound   = bound;
    cmd_in.desc    = desc_in;
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/fdeq_res_queue.sv @@
// Two-entry result queue between the back end and the result ports.
// Uses fdeq_pkg for the result struct.
`timescale 1ns / 1ps

module fdeq_res_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  fdeq_pkg::result_t din,
  output logic              full,
  input  logic              rd,
  output logic              empty,
  output fdeq_pkg::result_t dout
);
  import fdeq_pkg::*;

  result_t    q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_wr, do_rd;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = q[rp];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

@@ rtl/fdeq_back.sv @@
// Back end: holds the delayed entries in a circular store and runs the
// release sequencer. Uses fdeq_pkg; fed by fdeq_front, drains to fdeq_res_queue.
`timescale 1ns / 1ps

module fdeq_back #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  fdeq_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              res_push,
  output fdeq_pkg::result_t res_data,
  input  logic              res_full
);
  import fdeq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_entry;

  logic [1:0]        state, state_next;
  logic [IW-1:0]     head, head_next, head_inc, head_drop, waddr;
  logic [CW-1:0]     held_count, held_count_next, count_drop;
  logic [31:0]       overflow, overflow_next;
  logic [RUN_W-1:0]  run_n, run_n_next;
  logic [TIME_W-1:0] rel_now;
  logic              pend_valid, pend_valid_next;
  desc_t             pend_desc;
  logic              pend_load;
  logic              mem_we;
  logic              drop;
  logic [IW:0]       wsum;
  logic [TIME_W-1:0] diff;
  logic              is_due;

  assign head_inc = (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + IW'(1);
  assign drop     = (BOUND_W'(held_count) >= cmd.bound) && (held_count != '0);
  assign head_drop  = drop ? head_inc : head;
  assign count_drop = drop ? held_count - CW'(1) : held_count;
  assign wsum     = (IW + 1)'(head_drop) + (IW + 1)'(count_drop);
  assign waddr    = (wsum >= (IW + 1)'(QUEUE_DEPTH)) ?
                    IW'(wsum - (IW + 1)'(QUEUE_DEPTH)) : IW'(wsum);

  // wrap-aware compare: due when due - now is zero or negative
  assign diff   = rd_entry.due - rel_now;
  assign is_due = (diff == '0) || diff[TIME_W-1];

  assign res_data.desc    = pend_desc;
  assign res_data.dropped = overflow;
  assign res_data.last    = (state == ST_FINISH);

  always_comb begin
    state_next      = state;
    head_next       = head;
    held_count_next = held_count;
    overflow_next   = overflow;
    run_n_next      = run_n;
    pend_valid_next = pend_valid;
    pend_load       = 1'b0;
    cmd_pop         = 1'b0;
    mem_we          = 1'b0;
    res_push        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.func == FUNC_ARRIVE) begin
            mem_we          = 1'b1;
            head_next       = head_drop;
            held_count_next = count_drop + CW'(1);
            if (drop && overflow != 32'hFFFF_FFFF) begin
              overflow_next = overflow + 32'd1;
            end
          end else begin
            run_n_next = '0;
            if (held_count != '0) begin
              state_next = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!is_due) begin
          state_next = ST_FINISH;
        end else if (!(pend_valid && res_full)) begin
          // the previous entry is known not to be the last of the run
          res_push        = pend_valid;
          pend_load       = 1'b1;
          pend_valid_next = 1'b1;
          head_next       = head_inc;
          held_count_next = held_count - CW'(1);
          run_n_next      = run_n + RUN_W'(1);
          if (held_count_next != '0 && run_n_next != RUN_W'(MAX_OUT)) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (!res_full) begin
          res_push        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= '{due: cmd.time_ms, desc: cmd.desc};
    end
    rd_entry <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.func == FUNC_RELEASE) rel_now <= cmd.time_ms;
    if (pend_load) pend_desc <= rd_entry.desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      held_count <= '0;
      overflow   <= '0;
      run_n      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      held_count <= held_count_next;
      overflow   <= overflow_next;
      run_n      <= run_n_next;
      pend_valid <= pend_valid_next;
    end
  end

endmodule

@@ rtl/fixed_delay_event_queue_unit.sv @@
// Top level of the fixed-delay event queue: configuration registers and the
// front, back and result queue. Uses fdeq_pkg, fdeq_front, fdeq_back, fdeq_res_queue.
//
// Input channel: push/full. func = 0 holds an event due at now_ms plus the
// configured delay; func = 1 releases, oldest first, every held event due at
// or before now_ms (at most 32 per release), last_of_run marking the final one.
// Result channel: empty/pop; the oldest result sits on the out_* ports while
// empty is low. dropped_total is the saturating overflow count.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 = delay,
// 1 = holding bound) at the clock edge; the user must write only while the
// block is idle, which the block itself does not enforce. Throughput: an
// arrival is handled in the back end's idle state, so arrivals stream at one
// per cycle while no release is in progress. A release with nothing held
// returns straight to idle; otherwise it tests the held entries in turn
// (registered store read, one head entry tested at a time). The last result of
// a run waits until the next head is found not due or the run ends.
// Reset (rst, synchronous) empties the store and both queues and clears the
// counter; the delay resets to 0 and the bound to 32. When the receiver
// stalls, the two-entry result queue fills, the release sequencer waits and
// the command queue then fills, raising full.
`timescale 1ns / 1ps

module fixed_delay_event_queue_unit #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [31:0] now_ms,
  input  logic [2:0]  event_kind,
  input  logic [15:0] connection_id,
  input  logic [7:0]  channel_no,
  input  logic [7:0]  reason_code,
  input  logic [15:0] payload_ref,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [15:0] out_connection,
  output logic [7:0]  out_channel,
  output logic [7:0]  out_reason,
  output logic [15:0] out_payload_ref,
  output logic [31:0] dropped_total,
  output logic        last_of_run
);
  import fdeq_pkg::*;

  logic [DELAY_W-1:0] delay_ms;
  logic [MAXH_W-1:0]  max_held;
  desc_t              desc_in;
  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;
  logic               res_push, res_full;
  result_t            res_data, res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms <= '0;
      max_held <= MAXH_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY:    delay_ms <= cfg_data[DELAY_W-1:0];
        CFG_MAX_HELD: max_held <= cfg_data[MAXH_W-1:0];
        default:      ;
      endcase
    end
  end

  assign desc_in = '{kind: event_kind, conn: connection_id, chan: channel_no,
                     reason: reason_code, payload: payload_ref};

  fdeq_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .now_ms    (now_ms),
    .desc_in   (desc_in),
    .delay_ms  (delay_ms),
    .max_held  (max_held),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fdeq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  fdeq_res_queue u_resq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .din   (res_data),
    .full  (res_full),
    .rd    (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign out_kind        = res_out.desc.kind;
  assign out_connection  = res_out.desc.conn;
  assign out_channel     = res_out.desc.chan;
  assign out_reason      = res_out.desc.reason;
  assign out_payload_ref = res_out.desc.payload;
  assign dropped_total   = res_out.dropped;
  assign last_of_run     = res_out.last;

endmodule

@@ rtl/fdeq_checker.sv @@
// Port-level checker for fixed_delay_event_queue_unit, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps

module fdeq_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] dropped_total,
  input logic        last_of_run
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result waiting right after reset");

  // the overflow count seen on successive results never goes down
  a_drop_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!empty && !$past(rst) && $past(!empty && pop)) |->
      (dropped_total >= $past(dropped_total)))
    else $error("dropped_total went down between results");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(dropped_total) && $stable(last_of_run)))
    else $error("stalled result changed");

endmodule

bind fixed_delay_event_queue_unit fdeq_checker u_fdeq_checker (.*);

@@ dv/fdeq_release_checker.sv @@
// Checker for the fixed-delay event queue: follows the input, config and result
// channels, predicts released events and compares them field by field.
// Depends on fdeq_pkg.
`timescale 1ns / 1ps

module fdeq_release_checker
  import fdeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic        func,
  input  logic [31:0] now_ms,
  input  logic [2:0]  event_kind,
  input  logic [15:0] connection_id,
  input  logic [7:0]  channel_no,
  input  logic [7:0]  reason_code,
  input  logic [15:0] payload_ref,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_kind,
  input  logic [15:0] out_connection,
  input  logic [7:0]  out_channel,
  input  logic [7:0]  out_reason,
  input  logic [15:0] out_payload_ref,
  input  logic [31:0] dropped_total,
  input  logic        last_of_run,
  output int          fail_count,
  output int          awaited
);

  localparam int HELD_DEPTH = 32;

  entry_t      held_ring [HELD_DEPTH];
  int          head_ptr;
  int          held_n;
  logic [31:0] drop_total;
  logic [15:0] delay_ms;
  logic [5:0]  bound_cfg;
  result_t     released_q [$];

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    entry_t      arr;
    entry_t      head_e;
    result_t     r;
    logic [31:0] lag;
    int          lim;
    int          n;
    if (rst) begin
      head_ptr   = 0;
      held_n     = 0;
      drop_total = '0;
      delay_ms   = '0;
      bound_cfg  = 6'd32;
      released_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DELAY) delay_ms = cfg_data;
        else bound_cfg = cfg_data[5:0];
      end
      if (push && !full) begin
        if (func == FUNC_ARRIVE) begin
          lim = int'(bound_cfg);
          if (lim < 1) lim = 1;
          if (lim > HELD_DEPTH) lim = HELD_DEPTH;
          // drop-oldest: exactly one entry goes even if the bound was lowered
          if (held_n >= lim && held_n > 0) begin
            head_ptr = (head_ptr + 1) % HELD_DEPTH;
            held_n--;
            if (drop_total != 32'hFFFF_FFFF) drop_total++;
          end
          arr.due          = now_ms + 32'(delay_ms);
          arr.desc.kind    = event_kind;
          arr.desc.conn    = connection_id;
          arr.desc.chan    = channel_no;
          arr.desc.reason  = reason_code;
          arr.desc.payload = payload_ref;
          held_ring[(head_ptr + held_n) % HELD_DEPTH] = arr;
          held_n++;
        end else begin
          n = 0;
          while (held_n > 0 && n < MAX_OUT) begin
            head_e = held_ring[head_ptr];
            lag = head_e.due - now_ms;
            // due when the wrapped difference is zero or negative
            if (lag != 0 && !lag[31]) break;
            r.desc    = head_e.desc;
            r.dropped = drop_total;
            r.last    = 1'b0;
            released_q = {released_q, r};
            head_ptr = (head_ptr + 1) % HELD_DEPTH;
            held_n--;
            n++;
          end
          if (n > 0) begin
            released_q[released_q.size() - 1].last = 1'b1;
          end
        end
      end
      if (pop && !empty) begin
        if (released_q.size() == 0) begin
          $error("result transaction with nothing expected (kind %0d, conn 0x%0h)",
                 out_kind, out_connection);
          fail_count++;
        end else begin
          r = released_q[0];
          released_q.delete(0);
          compare_field("out_kind", 32'(r.desc.kind), 32'(out_kind));
          compare_field("out_connection", 32'(r.desc.conn), 32'(out_connection));
          compare_field("out_channel", 32'(r.desc.chan), 32'(out_channel));
          compare_field("out_reason", 32'(r.desc.reason), 32'(out_reason));
          compare_field("out_payload_ref", 32'(r.desc.payload), 32'(out_payload_ref));
          compare_field("dropped_total", r.dropped, dropped_total);
          compare_field("last_of_run", 32'(r.last), 32'(last_of_run));
        end
      end
    end
    awaited <= released_q.size();
  end

endmodule

@@ dv/tb_fixed_delay_event_queue_unit.sv @@
// Testbench top for fixed_delay_event_queue_unit: directed and random arrival and
// release traffic over several delay and bound settings, with random idling.
// Depends on fdeq_pkg, fixed_delay_event_queue_unit and fdeq_release_checker.
`timescale 1ns / 1ps

module tb_fixed_delay_event_queue_unit;
  import fdeq_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 7;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DELAY;
  logic [15:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic        func = FUNC_ARRIVE;
  logic [31:0] now_ms = '0;
  logic [2:0]  event_kind = '0;
  logic [15:0] connection_id = '0;
  logic [7:0]  channel_no = '0;
  logic [7:0]  reason_code = '0;
  logic [15:0] payload_ref = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_connection;
  logic [7:0]  out_channel;
  logic [7:0]  out_reason;
  logic [15:0] out_payload_ref;
  logic [31:0] dropped_total;
  logic        last_of_run;

  int          fail_count;
  int          awaited;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] t_ms = '0;
  logic [15:0] delay_now = '0;
  logic [15:0] delay_set [NUM_PHASES];
  logic [15:0] bound_set [NUM_PHASES];

  desc_t ones  = '1;
  desc_t zeros = '0;
  desc_t patt  = '{kind: 3'd5, conn: 16'hA5C3, chan: 8'h3C, reason: 8'h96,
                   payload: 16'h0F1E};

  fixed_delay_event_queue_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .func(func), .now_ms(now_ms),
    .event_kind(event_kind), .connection_id(connection_id),
    .channel_no(channel_no), .reason_code(reason_code), .payload_ref(payload_ref),
    .empty(empty), .pop(pop),
    .out_kind(out_kind), .out_connection(out_connection), .out_channel(out_channel),
    .out_reason(out_reason), .out_payload_ref(out_payload_ref),
    .dropped_total(dropped_total), .last_of_run(last_of_run)
  );

  fdeq_release_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .func(func), .now_ms(now_ms),
    .event_kind(event_kind), .connection_id(connection_id),
    .channel_no(channel_no), .reason_code(reason_code), .payload_ref(payload_ref),
    .empty(empty), .pop(pop),
    .out_kind(out_kind), .out_connection(out_connection), .out_channel(out_channel),
    .out_reason(out_reason), .out_payload_ref(out_payload_ref),
    .dropped_total(dropped_total), .last_of_run(last_of_run),
    .fail_count(fail_count), .awaited(awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             quiet_cycles, awaited);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic desc_t random_desc();
    desc_t d;
    d.kind    = 3'($urandom_range(0, 7));
    d.conn    = 16'($urandom());
    d.chan    = 8'($urandom());
    d.reason  = 8'($urandom());
    d.payload = 16'($urandom());
    return d;
  endfunction

  // leaves push high so back-to-back transactions need no second assignment
  task automatic send_event(input logic op, input logic [31:0] stamp, input desc_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    func          <= op;
    now_ms        <= stamp;
    event_kind    <= d.kind;
    connection_id <= d.conn;
    channel_no    <= d.chan;
    reason_code   <= d.reason;
    payload_ref   <= d.payload;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // drain every expected release, let trailing arrivals retire, then reprogram
  task automatic settle_and_write(input logic [15:0] dly, input logic [15:0] bound_word);
    push <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELAY;
    cfg_data  <= dly;
    @(posedge clk);
    cfg_index <= CFG_MAX_HELD;
    cfg_data  <= bound_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    delay_now = dly;
  endtask

  task automatic random_traffic(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      t_ms += $urandom_range(0, delay_now / 8 + 20);
      if (pick < 55)
        send_event(FUNC_ARRIVE, t_ms, random_desc());
      else if (pick < 80)
        send_event(FUNC_RELEASE, t_ms, random_desc());
      else if (pick < 90)
        send_event(FUNC_RELEASE, t_ms + delay_now + $urandom_range(0, 3), random_desc());
      else
        send_event($urandom_range(0, 1) ? FUNC_RELEASE : FUNC_ARRIVE, $urandom(),
                   random_desc());
    end
  endtask

  initial begin
    delay_set = '{16'd0, 16'hFFFF, 16'($urandom()), 16'($urandom_range(1, 200)),
                  16'hFFFF, 16'($urandom()), 16'd0};
    // bound 0 acts as 1, 63 clamps to the depth; junk above bit 5 is ignored
    bound_set = '{16'd32, 16'd0, {10'($urandom()), 6'd63}, 16'd1, 16'd32,
                  16'($urandom_range(2, 31)), 16'd5};
    send_idle_pct = 17;
    recv_idle_pct = 64;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset config: delay 0, bound 32
    send_event(FUNC_RELEASE, 32'h0, zeros);          // nothing held
    send_event(FUNC_ARRIVE, 32'hFFFF_FFF0, ones);
    send_event(FUNC_ARRIVE, 32'hFFFF_FFFF, zeros);
    send_event(FUNC_RELEASE, 32'hFFFF_FFEF, ones);   // one ms early
    send_event(FUNC_RELEASE, 32'h0000_0005, zeros);  // both due across the wrap
    send_event(FUNC_ARRIVE, 32'd100, patt);
    send_event(FUNC_RELEASE, 32'd99, patt);
    send_event(FUNC_RELEASE, 32'd100, ~patt);        // due exactly now
    send_event(FUNC_ARRIVE, 32'h10, ~patt);
    send_event(FUNC_RELEASE, 32'h8000_0011, ones);   // half range past reads as future
    send_event(FUNC_RELEASE, 32'h8000_0010, zeros);
    send_event(FUNC_ARRIVE, 32'h7FFF_FFFF, ones);
    send_event(FUNC_RELEASE, 32'h7FFF_FFFE, patt);
    send_event(FUNC_RELEASE, 32'hFFFF_FFFF, zeros);
    t_ms = $urandom();

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_and_write(delay_set[p], bound_set[p]);
      send_idle_pct = (p < 3) ? 17 : (p < 5) ? 64 : 0;
      recv_idle_pct = (p < 3) ? 64 : (p < 5) ? 17 : 0;
      if (p == 0 || p == 4) begin
        // overfill, then release everything: a full run of 32
        repeat (34) send_event(FUNC_ARRIVE, t_ms, random_desc());
        send_event(FUNC_RELEASE, t_ms + delay_now, random_desc());
      end
      random_traffic(16);
      // leave entries held so the next bound may sit below the count
      repeat (3) send_event(FUNC_ARRIVE, t_ms, random_desc());
    end

    push <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
